### sv/pptc_pkg.sv
// ----------------------------------------------------------------------------
// Push/pop trace classifier package
// Shared constants, operation and verdict codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pptc_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned ValW = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_STACK      = 3'd1,
    VERDICT_QUEUE      = 3'd2,
    VERDICT_PRIO       = 3'd3,
    VERDICT_UNSURE     = 3'd4,
    VERDICT_OVERFLOW   = 3'd5
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

### sv/pptc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pptc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

### sv/push_pop_trace_classifier.sv
// ----------------------------------------------------------------------------
// Push/pop trace classifier
// Checks a push/pop trace against a stack, a FIFO queue and a max-heap.
// ----------------------------------------------------------------------------
// One transfer is handled at a time; the input is not ready again until the
// transfer is through. A push writes each store that still fits in ST_READ
// and, when it enters the heap, climbs one level per ST_UP_RD/ST_UP_CMP pair
// until a compare stops it or it reaches the root. A pop reads the stores in
// ST_READ, checks them in ST_CHECK and, when it removes the heap maximum, moves
// the last entry to the root in ST_DN_LAST and walks down through ST_DN_RD,
// ST_DN_CMP and, where a right child exists, ST_OUT. Once a sequence has
// overflowed, each transfer goes straight to ST_DONE. The heap sift over its
// single RAM port sets the time taken. A verdict waits in an output register;
// the next transfer is accepted once that register is free.
`default_nettype none

module push_pop_trace_classifier
  import pptc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [6:0] item_value
  input  wire logic       s_axis_tuser,   // req_type
  input  wire logic       s_axis_tlast,   // last_item
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [2:0] verdict, [3] stack_fits,
                                          // [4] queue_fits, [5] heap_fits
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] Full = CW'(STORE_DEPTH);

  state_e st_q, st_d;
  logic pop_q, pop_d, last_q, last_d;
  logic [ValW-1:0] val_q, val_d;
  logic [CW-1:0] sdep_q, sdep_d, fhead_q, fhead_d, ftail_q, ftail_d;
  logic [CW-1:0] hsize_q, hsize_d, pos_q, pos_d, kid_q, kid_d;
  logic [ValW-1:0] cur_q, cur_d, kidv_q, kidv_d;
  logic [2:0] fit_q, fit_d;
  logic ovf_q, ovf_d;
  logic ov_q, ov_d;
  logic [7:0] od_q, od_d;

  logic s_we, f_we, h_we;
  logic [AW-1:0] s_a, f_a, h_a;
  logic [ValW-1:0] s_wd, f_wd, h_wd, s_rd, f_rd, h_rd;

  pptc_ram #(.Width(ValW), .Depth(STORE_DEPTH)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_a), .wdata_i(s_wd), .rdata_o(s_rd));
  pptc_ram #(.Width(ValW), .Depth(STORE_DEPTH)) u_fifo (
    .clk_i, .we_i(f_we), .addr_i(f_a), .wdata_i(f_wd), .rdata_o(f_rd));
  pptc_ram #(.Width(ValW), .Depth(STORE_DEPTH)) u_heap (
    .clk_i, .we_i(h_we), .addr_i(h_a), .wdata_i(h_wd), .rdata_o(h_rd));

  // Heap is 1-based; entry p lives at address p-1.
  function automatic logic [AW-1:0] hadr(input logic [CW-1:0] p);
    logic [CW-1:0] t;
    t = p - CW'(1);
    return t[AW-1:0];
  endfunction

  assign s_axis_tready = (st_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;

  always_comb begin
    logic [2:0] n;
    st_d = st_q; pop_d = pop_q; last_d = last_q; val_d = val_q;
    sdep_d = sdep_q; fhead_d = fhead_q; ftail_d = ftail_q; hsize_d = hsize_q;
    pos_d = pos_q; kid_d = kid_q; cur_d = cur_q; kidv_d = kidv_q;
    fit_d = fit_q; ovf_d = ovf_q; ov_d = ov_q; od_d = od_q;
    s_we = 1'b0; f_we = 1'b0; h_we = 1'b0;
    s_a = sdep_q[AW-1:0]; f_a = ftail_q[AW-1:0]; h_a = hadr(pos_q);
    s_wd = val_q; f_wd = val_q; h_wd = cur_q;
    n = 3'd0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid && !ov_q) begin
          pop_d = (s_axis_tuser == OP_POP);
          val_d = s_axis_tdata[ValW-1:0];
          last_d = s_axis_tlast;
          st_d = ovf_q ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (!pop_q) begin
          if (ftail_q >= Full) begin
            ovf_d = 1'b1;
            st_d = ST_DONE;
          end else begin
            if (fit_q[0] && sdep_q < Full) begin
              s_we = 1'b1;
              s_a = sdep_q[AW-1:0];
              sdep_d = sdep_q + CW'(1);
            end
            if (fit_q[1]) f_we = 1'b1;
            f_a = ftail_q[AW-1:0];
            ftail_d = ftail_q + CW'(1);
            if (fit_q[2] && hsize_q < Full) begin
              h_we = 1'b1;
              h_a = hadr(hsize_q + CW'(1));
              h_wd = val_q;
              hsize_d = hsize_q + CW'(1);
              pos_d = hsize_q + CW'(1);
              cur_d = val_q;
              st_d = ST_UP_RD;
            end else begin
              st_d = ST_DONE;
            end
          end
        end else begin
          s_a = hadr(sdep_q);
          f_a = fhead_q[AW-1:0];
          h_a = '0;
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        st_d = ST_DONE;
        if (fit_q[0]) begin
          if (sdep_q == '0 || s_rd != val_q) fit_d[0] = 1'b0;
          else sdep_d = sdep_q - CW'(1);
        end
        if (fit_q[1]) begin
          if (fhead_q >= ftail_q || f_rd != val_q) fit_d[1] = 1'b0;
          else fhead_d = fhead_q + CW'(1);
        end
        if (fit_q[2]) begin
          if (hsize_q == '0 || h_rd != val_q) fit_d[2] = 1'b0;
          else begin
            h_a = hadr(hsize_q);
            st_d = ST_DN_LAST;
          end
        end
      end
      ST_UP_RD: begin
        if (pos_q < CW'(2)) st_d = ST_DONE;
        else begin
          h_a = hadr(pos_q >> 1);
          st_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (cur_q > h_rd) begin
          h_we = 1'b1; h_a = hadr(pos_q); h_wd = h_rd;
          pos_d = pos_q >> 1;
          st_d = ST_UP_RD;
        end else begin
          h_we = 1'b1; h_a = hadr(pos_q); h_wd = cur_q;
          st_d = ST_DONE;
        end
        if (cur_q > h_rd && (pos_q >> 1) < CW'(2)) begin
          h_we = 1'b1; h_a = hadr(pos_q); h_wd = h_rd;
          st_d = ST_DN_LAST;
          pos_d = pos_q >> 1;
        end
      end
      ST_DN_LAST: begin
        // Also used as "write cur at pos and finish" after a climb to the root.
        if (!pop_q) begin
          h_we = 1'b1; h_a = hadr(pos_q); h_wd = cur_q;
          st_d = ST_DONE;
        end else begin
          cur_d = h_rd;
          hsize_d = hsize_q - CW'(1);
          pos_d = CW'(1);
          kid_d = CW'(2);
          st_d = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (kid_q > hsize_q) begin
          h_we = 1'b1; h_a = hadr(pos_q); h_wd = cur_q;
          st_d = ST_DONE;
        end else begin
          h_a = hadr(kid_q);
          st_d = ST_DN_CMP;
          kidv_d = '0;
          if (kid_q < hsize_q) st_d = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        // First cycle: h_rd = left child. Read right child if present.
        if (kid_q[0] == 1'b0 && kid_q < hsize_q && kidv_q == '0 && pos_q != kid_q) begin
          kidv_d = h_rd;
          h_a = hadr(kid_q + CW'(1));
          kid_d = kid_q + CW'(1);
          pos_d = pos_q;
          st_d = ST_OUT;
        end else begin
          if (h_rd <= cur_q) begin
            h_we = 1'b1; h_a = hadr(pos_q); h_wd = cur_q;
            st_d = ST_DONE;
          end else begin
            h_we = 1'b1; h_a = hadr(pos_q); h_wd = h_rd;
            pos_d = kid_q;
            kid_d = kid_q << 1;
            kidv_d = '0;
            st_d = ST_DN_RD;
          end
        end
      end
      ST_OUT: begin
        // Right child in h_rd, left child in kidv_q (kid_q points right).
        if (h_rd > kidv_q) begin
          if (h_rd <= cur_q) begin
            h_we = 1'b1; h_a = hadr(pos_q); h_wd = cur_q;
            st_d = ST_DONE;
          end else begin
            h_we = 1'b1; h_a = hadr(pos_q); h_wd = h_rd;
            pos_d = kid_q;
            kid_d = kid_q << 1;
            st_d = ST_DN_RD;
          end
        end else begin
          if (kidv_q <= cur_q) begin
            h_we = 1'b1; h_a = hadr(pos_q); h_wd = cur_q;
            st_d = ST_DONE;
          end else begin
            h_we = 1'b1; h_a = hadr(pos_q); h_wd = kidv_q;
            pos_d = kid_q - CW'(1);
            kid_d = (kid_q - CW'(1)) << 1;
            st_d = ST_DN_RD;
          end
        end
        kidv_d = '0;
      end
      ST_DONE: begin
        st_d = ST_IDLE;
        if (last_q) begin
          n = 3'(fit_q[0]) + 3'(fit_q[1]) + 3'(fit_q[2]);
          if (ovf_q) od_d = {5'd0, VERDICT_OVERFLOW};
          else begin
            priority if (n == 3'd0) od_d[2:0] = VERDICT_IMPOSSIBLE;
            else if (n > 3'd1) od_d[2:0] = VERDICT_UNSURE;
            else if (fit_q[0]) od_d[2:0] = VERDICT_STACK;
            else if (fit_q[1]) od_d[2:0] = VERDICT_QUEUE;
            else od_d[2:0] = VERDICT_PRIO;
            od_d[7:3] = {2'b00, fit_q};
          end
          ov_d = 1'b1;
          sdep_d = '0; fhead_d = '0; ftail_d = '0; hsize_d = '0;
          fit_d = 3'b111; ovf_d = 1'b0;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      sdep_q <= '0; fhead_q <= '0; ftail_q <= '0; hsize_q <= '0;
      fit_q <= 3'b111; ovf_q <= 1'b0; ov_q <= 1'b0;
      kidv_q <= '0;
    end else begin
      st_q <= st_d;
      sdep_q <= sdep_d; fhead_q <= fhead_d; ftail_q <= ftail_d; hsize_q <= hsize_d;
      fit_q <= fit_d; ovf_q <= ovf_d; ov_q <= ov_d;
      kidv_q <= kidv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_q <= pop_d; last_q <= last_d; val_q <= val_d;
    pos_q <= pos_d; kid_q <= kid_d; cur_q <= cur_d; od_q <= od_d;
  end

endmodule

`default_nettype wire

### bench/push_pop_trace_classifier_chk.sv
// ----------------------------------------------------------------------------
// Push/pop trace classifier checker
// Watches both streams, keeps its own stack, queue and max-heap, predicts the
// verdict of every sequence and compares it with the block's output.
// ----------------------------------------------------------------------------
module push_pop_trace_classifier_chk
  import pptc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  input  wire logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,
  input  wire logic       s_axis_tuser,
  input  wire logic       s_axis_tlast,
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,
  output int              errors_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic     heap_fits;
    logic     queue_fits;
    logic     stack_fits;
    verdict_e verdict;
  } verdict_t;

  logic [6:0] stk[StoreDepth];
  logic [6:0] fq[StoreDepth];
  logic [6:0] hp[StoreDepth + 1];
  int unsigned sdep, qhead, qtail, hsize;
  logic [2:0] fits;
  logic ovf;
  verdict_t verdicts_due[$];

  assign pending_o = verdicts_due.size();

  task automatic clear_trace();
    sdep = 0; qhead = 0; qtail = 0; hsize = 0; fits = 3'b111; ovf = 1'b0;
  endtask

  task automatic heap_push(input logic [6:0] v);
    int unsigned p;
    logic [6:0] t;
    if (hsize >= StoreDepth) return;
    hsize++;
    p = hsize;
    hp[p] = v;
    while (p >= 2 && hp[p] > hp[p >> 1]) begin
      t = hp[p]; hp[p] = hp[p >> 1]; hp[p >> 1] = t;
      p = p >> 1;
    end
  endtask

  task automatic heap_drop_max();
    int unsigned par, kid;
    logic [6:0] t;
    par = 1; kid = 2;
    hp[1] = hp[hsize];
    hsize--;
    while (kid <= hsize) begin
      if (kid < hsize && hp[kid + 1] > hp[kid]) kid++;
      if (hp[kid] <= hp[par]) break;
      t = hp[kid]; hp[kid] = hp[par]; hp[par] = t;
      par = kid;
      kid = par << 1;
    end
  endtask

  task automatic classify(input logic pop, input logic [6:0] v, input logic last);
    verdict_t r;
    int n;
    if (!ovf) begin
      if (!pop) begin
        if (qtail >= StoreDepth) begin
          ovf = 1'b1;
        end else begin
          if (fits[0] && sdep < StoreDepth) begin
            stk[sdep] = v; sdep++;
          end
          if (fits[1]) fq[qtail] = v;
          qtail++;
          if (fits[2]) heap_push(v);
        end
      end else begin
        if (fits[0]) begin
          if (sdep == 0 || stk[sdep - 1] != v) fits[0] = 1'b0;
          else sdep--;
        end
        if (fits[1]) begin
          if (qhead >= qtail || fq[qhead] != v) fits[1] = 1'b0;
          else qhead++;
        end
        if (fits[2]) begin
          if (hsize == 0 || hp[1] != v) fits[2] = 1'b0;
          else heap_drop_max();
        end
      end
    end
    if (!last) return;
    if (ovf) begin
      r = '{1'b0, 1'b0, 1'b0, VERDICT_OVERFLOW};
    end else begin
      n = fits[0] + fits[1] + fits[2];
      r.stack_fits = fits[0];
      r.queue_fits = fits[1];
      r.heap_fits = fits[2];
      if (n == 0) r.verdict = VERDICT_IMPOSSIBLE;
      else if (n > 1) r.verdict = VERDICT_UNSURE;
      else if (fits[0]) r.verdict = VERDICT_STACK;
      else if (fits[1]) r.verdict = VERDICT_QUEUE;
      else r.verdict = VERDICT_PRIO;
    end
    verdicts_due.push_back(r);
    clear_trace();
  endtask

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (!rst_ni) begin
      clear_trace();
      verdicts_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = verdict_t'(m_axis_tdata[5:0]);
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual %h", $time, got);
          errors_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want || m_axis_tdata[7:6] !== 2'b00) begin
            $display("%0t: verdict mismatch, expected %h, actual %h", $time, want,
                     m_axis_tdata);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        classify(s_axis_tuser == OP_POP, s_axis_tdata[6:0], s_axis_tlast);
    end
  end
endmodule

### bench/push_pop_trace_classifier_tb.sv
// ----------------------------------------------------------------------------
// Push/pop trace classifier testbench
// Drives directed and random push/pop sequences, the random ones with random gaps,
// under random output stalls; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module push_pop_trace_classifier_tb
  import pptc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  int errors, pending, idle_cycles, out_gap;

  always #5 clk_i = ~clk_i;

  push_pop_trace_classifier dut (.*);

  push_pop_trace_classifier_chk chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        m_axis_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) out_gap <= gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input op_e op, input logic [6:0] v, input logic last,
                      input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, v};
    s_axis_tuser <= op;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Well-formed pops follow stack, queue or max-heap order, or a random order, so verdicts vary.
  task automatic random_sequence(input int len);
    logic [6:0] held[$];
    logic [6:0] v;
    int kind, idx, k;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if (held.size() == 0 || $urandom_range(0, 1) == 0) begin
        v = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, 100));
        held.push_back(v);
        send(OP_PUSH, v, i == len - 1, 1'b1);
      end else begin
        idx = 0;
        if (kind == 0) idx = held.size() - 1;
        else if (kind == 2) begin
          for (k = 1; k < held.size(); k++) if (held[k] > held[idx]) idx = k;
        end else if (kind == 3) idx = $urandom_range(0, held.size() - 1);
        v = held[idx];
        held.delete(idx);
        if ($urandom_range(0, 19) == 0) v = 7'($urandom_range(0, 127));
        send(OP_POP, v, i == len - 1, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty pop, single-item last, extremes, each discipline.
    send(OP_POP, 7'd0, 1'b1, 1'b0);
    send(OP_PUSH, 7'd127, 1'b1, 1'b0);
    send(OP_PUSH, 7'd0, 1'b0, 1'b0);
    send(OP_PUSH, 7'd100, 1'b0, 1'b0);
    send(OP_POP, 7'd100, 1'b0, 1'b0);
    send(OP_POP, 7'd0, 1'b1, 1'b0);
    send(OP_PUSH, 7'd5, 1'b0, 1'b0);
    send(OP_PUSH, 7'd9, 1'b0, 1'b0);
    send(OP_POP, 7'd5, 1'b1, 1'b0);
    send(OP_PUSH, 7'd9, 1'b0, 1'b0);
    send(OP_PUSH, 7'd5, 1'b0, 1'b0);
    send(OP_POP, 7'd9, 1'b1, 1'b0);
    send(OP_PUSH, 7'd3, 1'b0, 1'b0);
    send(OP_POP, 7'd4, 1'b1, 1'b0);
    send(OP_PUSH, 7'd85, 1'b0, 1'b0);
    send(OP_PUSH, 7'd42, 1'b0, 1'b0);
    send(OP_POP, 7'd85, 1'b1, 1'b0);
    drain();
    // Overflow: one sequence pushes past the store depth.
    for (int i = 0; i <= StoreDepth; i++)
      send(OP_PUSH, 7'($urandom_range(0, 127)), 1'b0, 1'b0);
    send(OP_POP, 7'd1, 1'b0, 1'b0);
    send(OP_PUSH, 7'd1, 1'b1, 1'b0);
    drain();
    for (int n = 0; n < 700; ) begin
      int len;
      len = $urandom_range(1, 12);
      random_sequence(len);
      n += len;
    end
    drain();
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
